// ===== design/triangle_raster_depth_test_defines.svh =====
// Assertion macros for the triangle rasterizer.
// Taken in by the RTL files that assert; expects clk and rst_n in scope.
`ifndef TRIANGLE_RASTER_DEPTH_TEST_DEFINES_SVH
`define TRIANGLE_RASTER_DEPTH_TEST_DEFINES_SVH

// Same-cycle implication.
`define TRDT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TRDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/trdt_pkg.sv =====
// Shared types and constants of the triangle rasterizer.
// No dependencies.
package trdt_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);

    localparam int DET_W   = 35;   // signed determinant
    localparam int MAG_W   = 34;   // |det| with room to normalize
    localparam int W_W     = 38;   // signed edge values
    localparam int R_W     = 25;   // reciprocal mantissa
    localparam int E_W     = 6;    // bit length of |det|
    localparam int ACC_W   = 60;   // accumulator
    localparam int MA_W    = 26;   // multiplier operand a
    localparam int MB_W    = 19;   // multiplier operand b
    localparam int PROD_W  = MA_W + MB_W;
    localparam int DEPTH_W = 17;
    localparam int UV_W    = 16;
    localparam int HALF_W  = 17;   // low slice of an edge value

    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -17'sd65536;

    localparam logic MODE_VERTEX = 1'b0;
    localparam logic MODE_PIXEL  = 1'b1;

    localparam logic [1:0] VERTEX_LAST    = 2'd2;
    localparam logic [1:0] VERTEX_INVALID = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // accumulator term
    localparam logic [1:0] TERM_PLUS  = 2'd0;
    localparam logic [1:0] TERM_MINUS = 2'd1;
    localparam logic [1:0] TERM_SHL   = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DET0,
        S_DET1,
        S_DET2,
        S_CULL0,
        S_CULL1,
        S_NORM,
        S_DIV,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_P5,
        S_P6,
        S_B0,
        S_B1,
        S_B2,
        S_B3,
        S_B4,
        S_B5,
        S_B6,
        S_MAC,
        S_DEPTH,
        S_FINISH
    } state_t;

    // result fields, lowest bit last
    typedef struct packed {
        logic [UV_W-1:0]           frag_v;
        logic [UV_W-1:0]           frag_u;
        logic signed [DEPTH_W-1:0] frag_depth;
        logic                      fragment_written;
        logic                      covered;
        logic [7:0]                box_max_y;
        logic [7:0]                box_max_x;
        logic [7:0]                box_min_y;
        logic [7:0]                box_min_x;
        logic                      back_facing;
    } result_t;

    // last usable index for a configured dimension
    function automatic logic [7:0] dim_last(input logic [8:0] v, input int maxd);
        logic [8:0] lim;
        lim = 9'(maxd);
        if (v == 9'd0) begin
            return 8'd0;
        end
        if (v >= lim) begin
            return 8'(lim - 9'd1);
        end
        return 8'(v - 9'd1);
    endfunction

    function automatic logic [7:0] clamp_box(input logic signed [16:0] v,
                                             input logic [7:0] lim);
        if (v < 17'sd0) begin
            return 8'd0;
        end
        if (v > $signed({9'd0, lim})) begin
            return lim;
        end
        return v[7:0];
    endfunction

endpackage

// ===== design/triangle_raster_depth_test.sv =====
// Triangle rasterizer: vertex setup, barycentric coverage, reverse-Z depth test.
// Depends on trdt_pkg and triangle_raster_depth_test_defines.svh.
`include "triangle_raster_depth_test_defines.svh"
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  s        | s_tvalid / s_tready  | s_tdata vertex and pixel, s_tuser mode
//  m        | m_tvalid / m_tready  | m_tdata result fields, m_tuser setup_done
//  cfg      | cfg_we               | cfg_index, cfg_data (image size)
//
//  Vertex 0/1 load stores the vertex; vertex 2 load also runs setup, plus normalize
//  and 25 divide steps when det is nonzero; a pixel test ends early when rejected
//  or when outside the triangle.
//  All products run through one 26x19 multiplier and one 60-bit accumulator.
//  After reset the depth store is swept to the most negative depth with s_tready
//  low. Config writes are taken at any time.
//  A finished result waits in the output register; the next transaction is
//  accepted meanwhile and stalls only at its own completion.
module triangle_raster_depth_test (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_index[1:0] screen_x[17:2] screen_y[33:18] screen_depth[50:34]
    // clip_x[66:51] clip_y[82:67] tex_u[98:83] tex_v[114:99]
    // pixel_x[122:115] pixel_y[130:123], zero fill above
    input  logic [135:0] s_tdata,
    input  logic         s_tuser,     // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    // back_facing[0] box_min_x[8:1] box_min_y[16:9] box_max_x[24:17]
    // box_max_y[32:25] covered[33] fragment_written[34] frag_depth[51:35]
    // frag_u[67:52] frag_v[83:68], zero fill above
    output logic [87:0]  m_tdata,
    output logic         m_tuser,     // setup_done
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [8:0]   cfg_data
);
    import trdt_pkg::*;

    // ---------------- registers ----------------
    state_t                     state_reg, state_next;
    logic [4:0]                 cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    result_t                    out_res_reg, out_res_next;
    logic                       out_setup_reg, out_setup_next;
    result_t                    pend_reg, pend_next;
    logic                       pend_setup_reg, pend_setup_next;
    logic                       usable_reg, usable_next;
    logic [8:0]                 width_reg, width_next;
    logic [8:0]                 height_reg, height_next;
    logic [ADDR_W-1:0]          clr_addr_reg, clr_addr_next;

    // vertex store
    logic signed [15:0]         sx_reg [3];
    logic signed [15:0]         sx_next [3];
    logic signed [15:0]         sy_reg [3];
    logic signed [15:0]         sy_next [3];
    logic signed [DEPTH_W-1:0]  sz_reg [3];
    logic signed [DEPTH_W-1:0]  sz_next [3];
    logic signed [15:0]         cx_reg [3];
    logic signed [15:0]         cx_next [3];
    logic signed [15:0]         cy_reg [3];
    logic signed [15:0]         cy_next [3];
    logic [UV_W-1:0]            tu_reg [3];
    logic [UV_W-1:0]            tu_next [3];
    logic [UV_W-1:0]            tv_reg [3];
    logic [UV_W-1:0]            tv_next [3];

    // setup results and datapath
    logic                       inv_neg_reg, inv_neg_next;
    logic [E_W-1:0]             inv_e_reg, inv_e_next;
    logic [R_W-1:0]             inv_r_reg, inv_r_next;
    logic signed [DET_W-1:0]    det_reg, det_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [MAG_W-1:0]           dn_reg, dn_next;
    logic [MAG_W:0]             rem_reg, rem_next;
    logic signed [W_W-1:0]      w0_reg, w0_next;
    logic signed [W_W-1:0]      w1_reg, w1_next;
    logic signed [W_W-1:0]      w2_reg, w2_next;
    logic [DEPTH_W-1:0]         b0_reg, b0_next;
    logic [DEPTH_W-1:0]         b1_reg, b1_next;
    logic signed [DEPTH_W:0]    b2_reg, b2_next;
    logic [7:0]                 px_reg, px_next;
    logic [7:0]                 py_reg, py_next;
    logic signed [DEPTH_W-1:0]  rd_reg;

    // depth store
    logic signed [DEPTH_W-1:0]  depth_mem [MAX_WIDTH * MAX_HEIGHT];
    logic                       mem_we;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_waddr;
    logic signed [DEPTH_W-1:0]  mem_wdata;

    // ---------------- input fields ----------------
    logic [1:0]                 in_vi;
    logic signed [15:0]         in_sx, in_sy, in_cx, in_cy;
    logic signed [DEPTH_W-1:0]  in_sz;
    logic [UV_W-1:0]            in_tu, in_tv;
    logic [7:0]                 in_px, in_py;
    logic                       in_acc;

    assign in_vi  = s_tdata[1:0];
    assign in_sx  = s_tdata[17:2];
    assign in_sy  = s_tdata[33:18];
    assign in_sz  = s_tdata[50:34];
    assign in_cx  = s_tdata[66:51];
    assign in_cy  = s_tdata[82:67];
    assign in_tu  = s_tdata[98:83];
    assign in_tv  = s_tdata[114:99];
    assign in_px  = s_tdata[122:115];
    assign in_py  = s_tdata[130:123];

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg};
    assign m_tuser  = out_setup_reg;

    // ---------------- derived values ----------------
    logic [7:0]                 w_last, h_last;
    logic signed [16:0]         dx02, dx21, dy02, dy12;
    logic signed [16:0]         cax, cay, cbx, cby;
    logic signed [17:0]         rx, ry;
    logic signed [15:0]         mnx, mxx, mny, mxy;
    logic [6:0]                 b_shift;

    assign w_last = dim_last(width_reg, MAX_WIDTH);
    assign h_last = dim_last(height_reg, MAX_HEIGHT);

    // screen edges
    assign dx02 = 17'(sx_reg[0]) - 17'(sx_reg[2]);
    assign dx21 = 17'(sx_reg[2]) - 17'(sx_reg[1]);
    assign dy02 = 17'(sy_reg[0]) - 17'(sy_reg[2]);
    assign dy12 = 17'(sy_reg[1]) - 17'(sy_reg[2]);
    // clip edges for the facing test
    assign cax  = 17'(cx_reg[1]) - 17'(cx_reg[0]);
    assign cay  = 17'(cy_reg[1]) - 17'(cy_reg[0]);
    assign cbx  = 17'(cx_reg[2]) - 17'(cx_reg[0]);
    assign cby  = 17'(cy_reg[2]) - 17'(cy_reg[0]);
    // pixel corner relative to vertex 2, Q.4
    assign rx   = $signed({6'd0, px_reg, 4'd0}) - 18'(sx_reg[2]);
    assign ry   = $signed({6'd0, py_reg, 4'd0}) - 18'(sy_reg[2]);

    assign b_shift = 7'(inv_e_reg) + 7'd7;

    always_comb
    begin
        mnx = sx_reg[0];
        mxx = sx_reg[0];
        mny = sy_reg[0];
        mxy = sy_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (sx_reg[i] < mnx) mnx = sx_reg[i];
            if (sx_reg[i] > mxx) mxx = sx_reg[i];
            if (sy_reg[i] < mny) mny = sy_reg[i];
            if (sy_reg[i] > mxy) mxy = sy_reg[i];
        end
    end

    // ---------------- shared multiplier and accumulator ----------------
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic                       acc_clr;
    logic [1:0]                 term_sel;
    logic signed [ACC_W-1:0]    prod_ext, term, acc_sum, acc_q16;
    logic signed [MA_W-1:0]     r_op;

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_ext  = ACC_W'(prod_reg);
    assign r_op      = $signed({1'b0, inv_r_reg});
    assign acc_q16   = acc_sum >>> 16;

    always_comb
    begin
        case (term_sel)
            TERM_MINUS: term = -prod_ext;
            TERM_SHL:   term = prod_ext <<< HALF_W;
            default:    term = prod_ext;
        endcase
        acc_sum = (acc_clr ? '0 : acc_reg) + term;
    end

    // divider step
    logic                       rem_ge;
    logic [MAG_W:0]             rem_sub;
    logic [R_W-1:0]             q_step;

    assign rem_ge  = rem_reg >= {1'b0, dn_reg};
    assign rem_sub = rem_ge ? rem_reg - {1'b0, dn_reg} : rem_reg;
    assign q_step  = {inv_r_reg[R_W-2:0], rem_ge};

    // edge values with the winding folded in
    logic signed [W_W-1:0]      wf0, wf1, wf2;
    logic [ACC_W-1:0]           acc_shr;
    logic signed [DET_W-1:0]    det_abs;

    assign wf0     = inv_neg_reg ? -w0_reg : w0_reg;
    assign wf1     = inv_neg_reg ? -w1_reg : w1_reg;
    assign wf2     = inv_neg_reg ? -w2_reg : w2_reg;
    assign acc_shr = $unsigned(acc_reg) >> b_shift;
    assign det_abs = det_reg[DET_W-1] ? -det_reg : det_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        logic culled;
        logic usable;
        logic [DEPTH_W-1:0] b1v;

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        out_setup_next  = out_setup_reg;
        pend_next       = pend_reg;
        pend_setup_next = pend_setup_reg;
        usable_next     = usable_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        clr_addr_next   = clr_addr_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        sz_next         = sz_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        tu_next         = tu_reg;
        tv_next         = tv_reg;
        inv_neg_next    = inv_neg_reg;
        inv_e_next      = inv_e_reg;
        inv_r_next      = inv_r_reg;
        det_next        = det_reg;
        acc_next        = acc_reg;
        dn_next         = dn_reg;
        rem_next        = rem_reg;
        w0_next         = w0_reg;
        w1_next         = w1_reg;
        w2_next         = w2_reg;
        b0_next         = b0_reg;
        b1_next         = b1_reg;
        b2_next         = b2_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        mul_a           = '0;
        mul_b           = '0;
        acc_clr         = 1'b1;
        term_sel        = TERM_PLUS;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = {py_reg, px_reg};
        mem_wdata       = pend_reg.frag_depth;
        culled          = acc_sum[ACC_W-1];
        usable          = 1'b0;
        b1v             = acc_shr[DEPTH_W-1:0];

        if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
            begin
                width_next = cfg_data;
            end
            else
            begin
                height_next = cfg_data;
            end
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = DEPTH_MIN;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_acc)
                begin
                    pend_next       = '0;
                    pend_setup_next = 1'b0;
                    px_next         = in_px;
                    py_next         = in_py;
                    if (s_tuser == MODE_VERTEX)
                    begin
                        state_next = S_FINISH;
                        if (in_vi != VERTEX_INVALID)
                        begin
                            sx_next[in_vi] = in_sx;
                            sy_next[in_vi] = in_sy;
                            sz_next[in_vi] = in_sz;
                            cx_next[in_vi] = in_cx;
                            cy_next[in_vi] = in_cy;
                            tu_next[in_vi] = in_tu;
                            tv_next[in_vi] = in_tv;
                            usable_next    = 1'b0;
                            if (in_vi == VERTEX_LAST)
                            begin
                                state_next = S_DET0;
                            end
                        end
                    end
                    else if (usable_reg && in_px <= w_last && in_py <= h_last)
                    begin
                        state_next = S_P0;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            // det = dy12*dx02 + dx21*dy02
            S_DET0:
            begin
                mul_a      = MA_W'(dy12);
                mul_b      = MB_W'(dx02);
                state_next = S_DET1;
            end
            S_DET1:
            begin
                acc_next   = acc_sum;
                mul_a      = MA_W'(dx21);
                mul_b      = MB_W'(dy02);
                state_next = S_DET2;
            end
            S_DET2:
            begin
                acc_clr    = 1'b0;
                acc_next   = acc_sum;
                mul_a      = MA_W'(cax);
                mul_b      = MB_W'(cby);
                state_next = S_CULL0;
            end
            // facing: ax*by - ay*bx
            S_CULL0:
            begin
                det_next   = acc_reg[DET_W-1:0];
                acc_next   = acc_sum;
                mul_a      = MA_W'(cay);
                mul_b      = MB_W'(cbx);
                state_next = S_CULL1;
            end
            S_CULL1:
            begin
                acc_clr                = 1'b0;
                term_sel               = TERM_MINUS;
                usable                 = !culled && (det_reg != '0);
                usable_next            = usable;
                pend_setup_next        = 1'b1;
                pend_next.back_facing  = culled;
                if (usable)
                begin
                    pend_next.box_min_x = clamp_box(17'(mnx >>> 4), w_last);
                    pend_next.box_min_y = clamp_box(17'(mny >>> 4), h_last);
                    pend_next.box_max_x = clamp_box((17'(mxx) + 17'sd15) >>> 4, w_last);
                    pend_next.box_max_y = clamp_box((17'(mxy) + 17'sd15) >>> 4, h_last);
                end
                if (det_reg != '0)
                begin
                    inv_neg_next = det_reg[DET_W-1];
                    inv_e_next   = E_W'(MAG_W);
                    dn_next      = MAG_W'(det_abs);
                    state_next   = S_NORM;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // shift |det| up to bit MAG_W-1, counting its bit length down
            S_NORM:
            begin
                if (dn_reg[MAG_W-1])
                begin
                    rem_next   = (MAG_W+1)'(1) << (MAG_W - 1);
                    inv_r_next = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    dn_next    = {dn_reg[MAG_W-2:0], 1'b0};
                    inv_e_next = inv_e_reg - 1'b1;
                end
            end

            // restoring division, one quotient bit per cycle
            S_DIV:
            begin
                rem_next   = {rem_sub[MAG_W-1:0], 1'b0};
                inv_r_next = q_step;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == 5'(R_W - 1))
                begin
                    state_next = S_FINISH;
                end
            end

            // edge values w0, w1, w2
            S_P0:
            begin
                mem_re     = 1'b1;
                mul_a      = MA_W'(dy12);
                mul_b      = MB_W'(rx);
                state_next = S_P1;
            end
            S_P1:
            begin
                acc_next   = acc_sum;
                mul_a      = MA_W'(dx21);
                mul_b      = MB_W'(ry);
                state_next = S_P2;
            end
            S_P2:
            begin
                acc_clr    = 1'b0;
                acc_next   = acc_sum;
                mul_a      = MA_W'(dy02);
                mul_b      = MB_W'(rx);
                state_next = S_P3;
            end
            S_P3:
            begin
                w0_next    = acc_reg[W_W-1:0];
                term_sel   = TERM_MINUS;
                acc_next   = acc_sum;
                mul_a      = MA_W'(dx02);
                mul_b      = MB_W'(ry);
                state_next = S_P4;
            end
            S_P4:
            begin
                acc_clr    = 1'b0;
                acc_next   = acc_sum;
                state_next = S_P5;
            end
            S_P5:
            begin
                w1_next    = acc_reg[W_W-1:0];
                w2_next    = W_W'(det_reg) - w0_reg - acc_reg[W_W-1:0];
                state_next = S_P6;
            end
            S_P6:
            begin
                w0_next = wf0;
                w1_next = wf1;
                if (wf0[W_W-1] || wf1[W_W-1] || wf2[W_W-1])
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_B0;
                end
            end

            // b = (w * r) >> (e + 7), w split into two slices
            S_B0:
            begin
                mul_a      = r_op;
                mul_b      = $signed({2'd0, w0_reg[HALF_W-1:0]});
                state_next = S_B1;
            end
            S_B1:
            begin
                acc_next   = acc_sum;
                mul_a      = r_op;
                mul_b      = $signed({3'd0, w0_reg[2*HALF_W-2:HALF_W]});
                state_next = S_B2;
            end
            S_B2:
            begin
                acc_clr    = 1'b0;
                term_sel   = TERM_SHL;
                acc_next   = acc_sum;
                state_next = S_B3;
            end
            S_B3:
            begin
                b0_next    = acc_shr[DEPTH_W-1:0];
                mul_a      = r_op;
                mul_b      = $signed({2'd0, w1_reg[HALF_W-1:0]});
                state_next = S_B4;
            end
            S_B4:
            begin
                acc_next   = acc_sum;
                mul_a      = r_op;
                mul_b      = $signed({3'd0, w1_reg[2*HALF_W-2:HALF_W]});
                state_next = S_B5;
            end
            S_B5:
            begin
                acc_clr    = 1'b0;
                term_sel   = TERM_SHL;
                acc_next   = acc_sum;
                state_next = S_B6;
            end
            S_B6:
            begin
                b1_next    = b1v;
                b2_next    = (DEPTH_W+1)'(65536) - $signed({1'b0, b0_reg})
                             - $signed({1'b0, b1v});
                cnt_next   = '0;
                state_next = S_MAC;
            end

            // depth, u, v: three products each, summed, floored and clamped
            S_MAC:
            begin
                case (cnt_reg)
                    5'd0, 5'd3, 5'd6: mul_a = $signed({9'd0, b0_reg});
                    5'd1, 5'd4, 5'd7: mul_a = $signed({9'd0, b1_reg});
                    default:          mul_a = MA_W'(b2_reg);
                endcase
                case (cnt_reg)
                    5'd0:    mul_b = MB_W'(sz_reg[0]);
                    5'd1:    mul_b = MB_W'(sz_reg[1]);
                    5'd2:    mul_b = MB_W'(sz_reg[2]);
                    5'd3:    mul_b = $signed({3'd0, tu_reg[0]});
                    5'd4:    mul_b = $signed({3'd0, tu_reg[1]});
                    5'd5:    mul_b = $signed({3'd0, tu_reg[2]});
                    5'd6:    mul_b = $signed({3'd0, tv_reg[0]});
                    5'd7:    mul_b = $signed({3'd0, tv_reg[1]});
                    default: mul_b = $signed({3'd0, tv_reg[2]});
                endcase
                acc_clr  = (cnt_reg == 5'd1) || (cnt_reg == 5'd4) || (cnt_reg == 5'd7);
                if (cnt_reg != 5'd0)
                begin
                    acc_next = acc_sum;
                end
                if (cnt_reg == 5'd3)
                begin
                    if (acc_q16 < -60'sd65536)
                        pend_next.frag_depth = DEPTH_MIN;
                    else if (acc_q16 > 60'sd65535)
                        pend_next.frag_depth = 17'sd65535;
                    else
                        pend_next.frag_depth = acc_q16[DEPTH_W-1:0];
                end
                if (cnt_reg == 5'd6)
                begin
                    if (acc_q16 < 60'sd0)
                        pend_next.frag_u = '0;
                    else if (acc_q16 > 60'sd65535)
                        pend_next.frag_u = '1;
                    else
                        pend_next.frag_u = acc_q16[UV_W-1:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd9)
                begin
                    if (acc_q16 < 60'sd0)
                        pend_next.frag_v = '0;
                    else if (acc_q16 > 60'sd65535)
                        pend_next.frag_v = '1;
                    else
                        pend_next.frag_v = acc_q16[UV_W-1:0];
                    state_next = S_DEPTH;
                end
            end

            // reverse-Z: strictly greater wins
            S_DEPTH:
            begin
                pend_next.covered = 1'b1;
                if (pend_reg.frag_depth > rd_reg)
                begin
                    mem_we                     = 1'b1;
                    pend_next.fragment_written = 1'b1;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = pend_reg;
                    out_setup_next = pend_setup_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            usable_reg    <= 1'b0;
            width_reg     <= 9'(MAX_WIDTH);
            height_reg    <= 9'(MAX_HEIGHT);
            clr_addr_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sx_reg[i] <= '0;
                sy_reg[i] <= '0;
                sz_reg[i] <= '0;
                cx_reg[i] <= '0;
                cy_reg[i] <= '0;
                tu_reg[i] <= '0;
                tv_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            usable_reg    <= usable_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            clr_addr_reg  <= clr_addr_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            sz_reg        <= sz_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            tu_reg        <= tu_next;
            tv_reg        <= tv_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        out_res_reg    <= out_res_next;
        out_setup_reg  <= out_setup_next;
        pend_reg       <= pend_next;
        pend_setup_reg <= pend_setup_next;
        inv_neg_reg    <= inv_neg_next;
        inv_e_reg      <= inv_e_next;
        inv_r_reg      <= inv_r_next;
        det_reg        <= det_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        dn_reg         <= dn_next;
        rem_reg        <= rem_next;
        w0_reg         <= w0_next;
        w1_reg         <= w1_next;
        w2_reg         <= w2_next;
        b0_reg         <= b0_next;
        b1_reg         <= b1_next;
        b2_reg         <= b2_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
    end

    // depth store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            depth_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= depth_mem[{py_reg, px_reg}];
        end
    end

    // ---------------- assertions ----------------
    `TRDT_ASSERT_NOW(a_written_is_covered, m_tvalid && out_res_reg.fragment_written, out_res_reg.covered, "write without coverage")
    `TRDT_ASSERT_NOW(a_setup_no_fragment, m_tvalid && out_setup_reg, !out_res_reg.covered, "setup result covers a pixel")
    `TRDT_ASSERT_NOW(a_culled_empty_box, m_tvalid && out_res_reg.back_facing, (out_res_reg.box_max_x == 8'd0) && (out_res_reg.box_max_y == 8'd0), "culled triangle with a box")
    `TRDT_ASSERT_NEXT(a_no_triangle_reject, in_acc && (s_tuser == MODE_PIXEL) && !usable_reg, state_reg == S_FINISH, "pixel tested without a triangle")

endmodule
